// ----- rtl/core/bcp_pkg.sv -----
`default_nettype none
package bcp_pkg;

    localparam int unsigned FIELD_W = 6;
    localparam int unsigned COEF_W  = 30;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 32;

    typedef struct packed {
        logic init;
        logic step;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
    } t_dp_sts;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/bcp_datapath.sv -----
`default_nettype none
module bcp_datapath #(
    parameter int unsigned MAX_N = 32
) (
    input  wire logic                           i_clk,
    input  wire bcp_pkg::t_dp_cmd               i_cmd,
    output bcp_pkg::t_dp_sts                    o_sts,
    input  wire logic [bcp_pkg::FIELD_W-1:0]    i_n_value,
    input  wire logic [bcp_pkg::FIELD_W-1:0]    i_k_index,
    output logic      [bcp_pkg::COEF_W-1:0]     o_coefficient
);
    import bcp_pkg::*;

    localparam int unsigned ROW_DEPTH = MAX_N + 1;
    localparam int unsigned IDX_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam logic [FIELD_W-1:0] MAX_V = FIELD_W'(MAX_N);

    logic [COEF_W-1:0]  r_row [ROW_DEPTH];
    logic [COEF_W-1:0]  n_row [ROW_DEPTH];
    logic [FIELD_W-1:0] r_cnt, n_cnt;
    logic [FIELD_W-1:0] r_k, n_k;
    logic               r_oor, n_oor;
    logic [COEF_W-1:0]  r_coef, n_coef;
    logic               in_oor;

    assign in_oor = (i_n_value > MAX_V) || (i_k_index > MAX_V);

    // one Pascal row per step, every cell but cell 0 adds its lower neighbor
    always_comb begin
        for (int j = 0; j < ROW_DEPTH; j++) begin
            if (i_cmd.init) begin
                n_row[j] = (j == 0) ? COEF_W'(1) : '0;
            end else if (i_cmd.step && j > 0) begin
                n_row[j] = r_row[j] + r_row[j-1];
            end else begin
                n_row[j] = r_row[j];
            end
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_k    = r_k;
        n_oor  = r_oor;
        n_coef = r_coef;
        if (i_cmd.init) begin
            n_cnt = in_oor ? '0 : i_n_value;
            n_k   = i_k_index;
            n_oor = in_oor;
        end else if (i_cmd.step) begin
            n_cnt = r_cnt - FIELD_W'(1);
        end
        if (i_cmd.load) begin
            n_coef = r_oor ? '0 : r_row[r_k[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ROW_DEPTH; j++) begin
            r_row[j] <= n_row[j];
        end
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_oor  <= n_oor;
        r_coef <= n_coef;
    end

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_coefficient  = r_coef;

endmodule
`default_nettype wire

// ----- rtl/core/bcp_ctrl.sv -----
`default_nettype none
module bcp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output bcp_pkg::t_dp_cmd        o_cmd,
    input  wire bcp_pkg::t_dp_sts   i_sts
);
    import bcp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.init = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_sts.cnt_zero) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

// ----- rtl/core/binomial_coefficient_pascal.sv -----
// ST_IDLE takes a request; ST_RUN builds rows up to n (n = n_value, 0 if out of range),
// then loads the result. The adder cells advance one row a cycle; no new request meanwhile.
// A new request is taken while the previous result still waits in the output register;
// its result load then holds until that result is taken.
// Reset: synchronous active-low i_rst_n clears the controller and output valid;
// the row store is rebuilt at the start of every request and needs no reset.
`default_nettype none
module binomial_coefficient_pascal #(
    parameter int unsigned MAX_N = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [bcp_pkg::S_DATA_W-1:0]       i_s_tdata,  // [5:0] n_value, [11:6] k_index
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [bcp_pkg::M_DATA_W-1:0]       o_m_tdata   // [29:0] coefficient
);
    import bcp_pkg::*;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [COEF_W-1:0]  coefficient;

    bcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bcp_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_n_value     (i_s_tdata[FIELD_W-1:0]),
        .i_k_index     (i_s_tdata[2*FIELD_W-1:FIELD_W]),
        .o_coefficient (coefficient)
    );

    assign o_m_tdata = {{(M_DATA_W-COEF_W){1'b0}}, coefficient};

endmodule
`default_nettype wire
